// ===== sv/ffdl_pkg.sv =====
// Shared constants and types for the fractional feedback delay line.
`timescale 1ns / 1ps
`default_nettype none

package ffdl_pkg;

  localparam int DEPTH = 4096;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W = 16;
  localparam int DELAY_W = 20;
  localparam int FRAC_W = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'd1;

  localparam logic [DELAY_W-1:0] DELAY_MIN = DELAY_W'(256);
  localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'((DEPTH - 1) * 256);
  localparam logic [FRAC_W-1:0] FRAC_FAR_MIN = 8'd254;

  localparam logic signed [SAMPLE_W+1:0] SAT_MAX = 26'sd8388607;
  localparam logic signed [SAMPLE_W+1:0] SAT_MIN = -26'sd8388608;

  // Serial multiplier: signed multiplicand times signed multiplier, one bit per cycle.
  localparam int MUL_A_W = SAMPLE_W + 1;
  localparam int MUL_B_W = GAIN_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

`default_nettype wire

// ===== sv/ffdl_store.sv =====
// Sample ring memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ffdl_store (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [ffdl_pkg::ADDR_W-1:0]        waddr,
  input  wire logic signed [ffdl_pkg::SAMPLE_W-1:0] wdata,
  input  wire logic [ffdl_pkg::ADDR_W-1:0]        raddr,
  output logic signed [ffdl_pkg::SAMPLE_W-1:0]    rdata
);

  logic signed [ffdl_pkg::SAMPLE_W-1:0] mem [ffdl_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/ffdl_smul.sv =====
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ffdl_smul (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [ffdl_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [ffdl_pkg::MUL_B_W-1:0]  b,
  output ffdl_pkg::mul_status_t                     status,
  output logic signed [ffdl_pkg::MUL_P_W-1:0]       product
);

  localparam logic [ffdl_pkg::MUL_CNT_W-1:0] LAST_STEP =
    ffdl_pkg::MUL_CNT_W'(ffdl_pkg::MUL_B_W - 1);

  logic signed [ffdl_pkg::MUL_A_W-1:0] mcand;
  logic signed [ffdl_pkg::MUL_A_W-1:0] hi;
  logic [ffdl_pkg::MUL_B_W-1:0]        lo;
  logic [ffdl_pkg::MUL_CNT_W-1:0]      cnt;
  logic                                running;
  logic                                done;
  logic signed [ffdl_pkg::MUL_A_W:0]   addend;
  logic signed [ffdl_pkg::MUL_A_W:0]   sum;

  // The sign bit of the multiplier carries negative weight, so it subtracts.
  always_comb begin
    if (!lo[0]) begin
      addend = '0;
    end else if (cnt == LAST_STEP) begin
      addend = -{mcand[ffdl_pkg::MUL_A_W-1], mcand};
    end else begin
      addend = {mcand[ffdl_pkg::MUL_A_W-1], mcand};
    end
    sum = {hi[ffdl_pkg::MUL_A_W-1], hi} + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= running && !start && (cnt == LAST_STEP);
      if (start) begin
        mcand <= a;
        hi <= '0;
        lo <= b;
        cnt <= '0;
        running <= 1'b1;
      end else if (running) begin
        hi <= sum[ffdl_pkg::MUL_A_W:1];
        lo <= {sum[0], lo[ffdl_pkg::MUL_B_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          running <= 1'b0;
        end
      end
    end
  end

  assign product = {hi, lo};
  assign status.busy = running;
  assign status.done = done;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) running |-> !start)
    else $error("Multiplier started while busy.");
`endif

endmodule

`default_nettype wire

// ===== sv/fractional_feedback_delay_line.sv =====
// Top level of the fractional feedback delay line with linear interpolation.
//
// Channel   Direction  Payload
// s_*       in         tdata[23:0] sample_in, signed Q1.23
// m_*       out        tdata[23:0] sample_out, signed Q1.23
// cfg_*     in         index 0 delay_samples_q8, index 1 feedback_gain
//
// One item is in work at a time. The serial multiplier, with 16 steps each use,
// is used twice for an item when the delay fraction needs interpolation and once
// otherwise. A result waits in the output register while the next item is
// accepted; the store update stalls only if that register is still full.
// Reset is synchronous; no clearing pass is needed, since a fill mark makes
// never written entries of the ring read as zero.
`timescale 1ns / 1ps
`default_nettype none

module fractional_feedback_delay_line (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [23:0]                        s_tdata,   // [23:0] sample_in
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [23:0]                             m_tdata,   // [23:0] sample_out
  input  wire logic                               cfg_write,
  input  wire logic [ffdl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ffdl_pkg::DELAY_W-1:0]       cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_FAR,
    S_CAP_FAR,
    S_SEL,
    S_INTERP,
    S_GAIN,
    S_FBK,
    S_OUT
  } state_t;

  state_t state;

  logic [ffdl_pkg::DELAY_W-1:0]         delay;
  logic signed [ffdl_pkg::GAIN_W-1:0]   gain;
  logic [ffdl_pkg::ADDR_W-1:0]          wp;
  logic                                 full;

  logic signed [ffdl_pkg::SAMPLE_W-1:0] x;
  logic signed [ffdl_pkg::SAMPLE_W-1:0] near;
  logic signed [ffdl_pkg::SAMPLE_W-1:0] far;
  logic signed [ffdl_pkg::SAMPLE_W-1:0] y;
  logic signed [ffdl_pkg::SAMPLE_W-1:0] wval;
  logic                                 near_ok;
  logic                                 far_ok;

  logic [ffdl_pkg::ADDR_W-1:0]          near_addr;
  logic [ffdl_pkg::ADDR_W-1:0]          raddr;
  logic                                 raddr_ok;
  logic signed [ffdl_pkg::SAMPLE_W-1:0] rdata;
  logic                                 mem_we;
  logic [ffdl_pkg::FRAC_W-1:0]          frac;
  logic                                 use_interp;

  logic                                 mul_start;
  logic signed [ffdl_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [ffdl_pkg::MUL_B_W-1:0]  mul_b;
  ffdl_pkg::mul_status_t                mul_st;
  logic signed [ffdl_pkg::MUL_P_W-1:0]  mul_prod;

  logic signed [33:0]                   interp_acc;
  logic signed [ffdl_pkg::MUL_P_W-1:0]  fb_acc;
  logic signed [ffdl_pkg::SAMPLE_W+1:0] fb;
  logic signed [ffdl_pkg::SAMPLE_W+1:0] store_sum;
  logic signed [ffdl_pkg::SAMPLE_W-1:0] store_sat;

  assign frac = delay[ffdl_pkg::FRAC_W-1:0];
  assign use_interp = (frac != '0) && (frac < ffdl_pkg::FRAC_FAR_MIN);

  // Read the near tap while idle and the far tap in the cycle after.
  assign near_addr = wp - delay[ffdl_pkg::DELAY_W-1:ffdl_pkg::FRAC_W];
  assign raddr = (state == S_IDLE) ? near_addr : near_addr - 1'b1;
  assign raddr_ok = full || (raddr < wp);

  assign s_tready = (state == S_IDLE);
  assign mem_we = (state == S_OUT) && (!m_tvalid || m_tready);

  assign mul_start = ((state == S_SEL) && use_interp) || (state == S_GAIN);
  assign mul_a = (state == S_SEL) ? ({far[ffdl_pkg::SAMPLE_W-1], far} -
                                     {near[ffdl_pkg::SAMPLE_W-1], near})
                                  : {y[ffdl_pkg::SAMPLE_W-1], y};
  assign mul_b = (state == S_SEL) ? {{(ffdl_pkg::MUL_B_W - ffdl_pkg::FRAC_W){1'b0}}, frac}
                                  : gain;

  // Interpolation as near*256 + (far - near)*frac, rounded half up.
  assign interp_acc = {{2{near[ffdl_pkg::SAMPLE_W-1]}}, near, 8'd0} + mul_prod[33:0] + 34'sd128;

  assign fb_acc = mul_prod + ffdl_pkg::MUL_P_W'(16384);
  assign fb = fb_acc[ffdl_pkg::MUL_P_W-1:15];
  assign store_sum = {{2{x[ffdl_pkg::SAMPLE_W-1]}}, x} + fb;

  always_comb begin
    if (store_sum > ffdl_pkg::SAT_MAX) begin
      store_sat = ffdl_pkg::SAT_MAX[ffdl_pkg::SAMPLE_W-1:0];
    end else if (store_sum < ffdl_pkg::SAT_MIN) begin
      store_sat = ffdl_pkg::SAT_MIN[ffdl_pkg::SAMPLE_W-1:0];
    end else begin
      store_sat = store_sum[ffdl_pkg::SAMPLE_W-1:0];
    end
  end

  ffdl_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rdata)
  );

  ffdl_smul u_smul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .status  (mul_st),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay <= ffdl_pkg::DELAY_MIN;
      gain <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ffdl_pkg::REG_DELAY: begin
          if (cfg_data < ffdl_pkg::DELAY_MIN) begin
            delay <= ffdl_pkg::DELAY_MIN;
          end else if (cfg_data > ffdl_pkg::DELAY_MAX) begin
            delay <= ffdl_pkg::DELAY_MAX;
          end else begin
            delay <= cfg_data;
          end
        end
        ffdl_pkg::REG_GAIN: begin
          gain <= cfg_data[ffdl_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      wp <= '0;
      full <= 1'b0;
    end else begin
      if (mem_we) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x <= s_tdata;
            near_ok <= raddr_ok;
            state <= S_RD_FAR;
          end
        end
        S_RD_FAR: begin
          near <= near_ok ? rdata : '0;
          far_ok <= raddr_ok;
          state <= S_CAP_FAR;
        end
        S_CAP_FAR: begin
          far <= far_ok ? rdata : '0;
          state <= S_SEL;
        end
        S_SEL: begin
          if (use_interp) begin
            state <= S_INTERP;
          end else begin
            y <= (frac == '0) ? near : far;
            state <= S_GAIN;
          end
        end
        S_INTERP: begin
          if (mul_st.done) begin
            y <= interp_acc[31:8];
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          state <= S_FBK;
        end
        S_FBK: begin
          if (mul_st.done) begin
            wval <= store_sat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (mem_we) begin
            m_tdata <= y;
            wp <= wp + 1'b1;
            if (wp == ffdl_pkg::ADDR_W'(ffdl_pkg::DEPTH - 1)) begin
              full <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_RD_FAR))
    else $error("Accepted item did not start the far tap read.");

  a_done_where_waited: assert property (@(posedge clk) disable iff (rst)
    mul_st.done |-> (state == S_INTERP || state == S_FBK))
    else $error("Multiplier finished outside a waiting state.");

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (wp == ffdl_pkg::ADDR_W'($past(wp) + 1'b1)))
    else $error("Write position did not advance after a store update.");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst) full |=> full)
    else $error("Fill mark dropped without reset.");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the fractional feedback delay line.
`timescale 1ns / 1ps

module tb_top;

  localparam int SEGMENTS = 12;
  localparam int SEGMENT_ITEMS = 104;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT = 5000;

  class echo_tracker;
    logic signed [ffdl_pkg::SAMPLE_W-1:0] ring [ffdl_pkg::DEPTH];
    logic [ffdl_pkg::ADDR_W-1:0] wr_pos;
    logic [ffdl_pkg::DELAY_W-1:0] delay_q8;
    logic signed [ffdl_pkg::GAIN_W-1:0] gain;
    logic [ffdl_pkg::SAMPLE_W-1:0] echoes_due [$];
    int mismatches = 0;
    int taken = 0;
    int checked = 0;
    int blended = 0;
    int far_only = 0;
    int whole_only = 0;
    int clipped = 0;
    int reg_writes = 0;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos = '0;
      delay_q8 = ffdl_pkg::DELAY_MIN;
      gain = '0;
    endfunction

    function void set_register(logic [ffdl_pkg::CFG_IDX_W-1:0] idx,
                               logic [ffdl_pkg::DELAY_W-1:0] data);
      reg_writes++;
      if (idx == ffdl_pkg::REG_DELAY) begin
        if (data < ffdl_pkg::DELAY_MIN) delay_q8 = ffdl_pkg::DELAY_MIN;
        else if (data > ffdl_pkg::DELAY_MAX) delay_q8 = ffdl_pkg::DELAY_MAX;
        else delay_q8 = data;
      end else if (idx == ffdl_pkg::REG_GAIN) begin
        gain = data[ffdl_pkg::GAIN_W-1:0];
      end
    endfunction

    function void predict_echo(logic [ffdl_pkg::SAMPLE_W-1:0] raw);
      logic [ffdl_pkg::ADDR_W-1:0] whole;
      logic [ffdl_pkg::ADDR_W-1:0] near_at;
      logic [ffdl_pkg::ADDR_W-1:0] far_at;
      logic signed [ffdl_pkg::SAMPLE_W-1:0] x_in;
      int frac;
      longint near_v;
      longint far_v;
      longint y;
      longint fb;
      longint s;
      whole = delay_q8[ffdl_pkg::DELAY_W-1:ffdl_pkg::FRAC_W];
      frac = delay_q8[ffdl_pkg::FRAC_W-1:0];
      near_at = wr_pos - whole;
      far_at = near_at - 1'b1;
      near_v = ring[near_at];
      far_v = ring[far_at];
      x_in = raw;
      if (frac == 0) begin
        y = near_v;
        whole_only++;
      end else if (frac < ffdl_pkg::FRAC_FAR_MIN) begin
        y = (near_v * (256 - frac) + far_v * frac + 128) >>> 8;
        blended++;
      end else begin
        y = far_v;
        far_only++;
      end
      fb = (y * gain + 16384) >>> 15;
      s = x_in + fb;
      if (s > ffdl_pkg::SAT_MAX) begin
        s = ffdl_pkg::SAT_MAX;
        clipped++;
      end else if (s < ffdl_pkg::SAT_MIN) begin
        s = ffdl_pkg::SAT_MIN;
        clipped++;
      end
      ring[wr_pos] = s[ffdl_pkg::SAMPLE_W-1:0];
      wr_pos = wr_pos + 1'b1;
      echoes_due.push_back(y[ffdl_pkg::SAMPLE_W-1:0]);
      taken++;
    endfunction

    function void check_echo(logic [ffdl_pkg::SAMPLE_W-1:0] got);
      logic [ffdl_pkg::SAMPLE_W-1:0] want;
      if (echoes_due.size() == 0) begin
        $error("sample_out: no item expected, got %0d", $signed(got));
        mismatches++;
        return;
      end
      want = echoes_due.pop_front();
      checked++;
      if (got !== want) begin
        $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ffdl_pkg::SAMPLE_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ffdl_pkg::SAMPLE_W-1:0] m_tdata;
  logic cfg_write = 1'b0;
  logic [ffdl_pkg::CFG_IDX_W-1:0] cfg_index = ffdl_pkg::REG_DELAY;
  logic [ffdl_pkg::DELAY_W-1:0] cfg_data = '0;

  int send_idle = 23;
  int recv_idle = 58;
  int quiet = 0;
  echo_tracker model = new();

  always #5 clk = ~clk;

  fractional_feedback_delay_line u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) model.check_echo(m_tdata);
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("** fractional_feedback_delay_line: FAILED **");
      $finish;
    end
  end

  task automatic send_sample(input logic [ffdl_pkg::SAMPLE_W-1:0] x);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= x;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.predict_echo(x);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (model.echoes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [ffdl_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ffdl_pkg::DELAY_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    model.set_register(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ffdl_pkg::SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(int'($urandom_range(0, 510)) - 255);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [ffdl_pkg::DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0: return 20'($urandom_range(1, 8) << 8);
      1: return 20'(($urandom_range(1, 32) << 8) + $urandom_range(1, 253));
      2: return 20'(($urandom_range(1, 32) << 8) + $urandom_range(254, 255));
      3: return 20'(($urandom_range(1, 16) << 8) + $urandom_range(0, 255));
      4: return 20'($urandom);
      5: return 20'($urandom_range(0, 255));
      6: return 20'(($urandom_range(1000, 4095) << 8) + $urandom_range(0, 255));
      default: return 20'($urandom_range(256, 767));
    endcase
  endfunction

  function automatic logic [ffdl_pkg::DELAY_W-1:0] pick_gain();
    logic [ffdl_pkg::GAIN_W-1:0] g;
    case ($urandom_range(0, 5))
      0: g = 16'h7FFF;
      1: g = 16'h8000;
      2: g = '0;
      3: g = 16'(int'($urandom_range(0, 16384)) - 8192);
      default: g = 16'($urandom);
    endcase
    return {4'($urandom), g};
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000001);
    send_sample(24'hFFFFFF);

    settle();
    write_register(ffdl_pkg::REG_DELAY, 20'h00000);
    write_register(ffdl_pkg::REG_GAIN, 20'hF7FFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h800000);

    settle();
    write_register(ffdl_pkg::REG_DELAY, 20'(2 * 256 + 1));
    write_register(ffdl_pkg::REG_GAIN, 20'h08000);
    send_sample(24'h123456);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);

    settle();
    write_register(ffdl_pkg::REG_DELAY, 20'(3 * 256 + 253));
    send_sample(24'h7FFFFF);
    send_sample(24'h000000);
    send_sample(24'h800000);

    settle();
    write_register(ffdl_pkg::REG_DELAY, 20'(2 * 256 + 254));
    send_sample(24'h400000);
    send_sample(24'hC00000);

    settle();
    write_register(ffdl_pkg::REG_DELAY, 20'(2 * 256 + 255));
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);

    settle();
    write_register(ffdl_pkg::REG_DELAY, 20'hFFFFF);
    write_register(ffdl_pkg::REG_GAIN, 20'h00001);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);

    settle();
    write_register(ffdl_pkg::REG_DELAY, 20'd255);
    send_sample(24'h000001);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      write_register(ffdl_pkg::REG_DELAY, pick_delay());
      write_register(ffdl_pkg::REG_GAIN, pick_gain());
      case (seg / 4)
        0: begin
          send_idle = 23;
          recv_idle = 58;
        end
        1: begin
          send_idle = 58;
          recv_idle = 23;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (SEGMENT_ITEMS) send_sample(draw_sample());
    end

    s_tvalid <= 1'b0;
    while (model.echoes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results over %0d register writes.",
             model.taken, model.checked, model.reg_writes);
    $display("Paths: %0d integer, %0d blended, %0d far-only; %0d saturated writes.",
             model.whole_only, model.blended, model.far_only, model.clipped);
    if (model.mismatches == 0) begin
      $display("** fractional_feedback_delay_line: PASSED **");
    end else begin
      $display("** fractional_feedback_delay_line: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ffdl_pkg.sv
sv/ffdl_store.sv
sv/ffdl_smul.sv
sv/fractional_feedback_delay_line.sv
test/tb_top.sv
